>>> hdl/blit_pkg.sv
// Shared types and constants for the clipped rectangle blitter.
package blit_pkg;

  localparam int unsigned MaxScreenWidth  = 256;
  localparam int unsigned MaxScreenHeight = 256;
  localparam int unsigned PixW            = 32;
  localparam int unsigned CfgAddrW        = 5;

  typedef enum logic [1:0] {
    MODE_DRAW = 2'd0,
    MODE_READ = 2'd1,
    MODE_LOAD = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    KIND_COPY       = 3'd0,
    KIND_BLEND_SRC  = 3'd1,
    KIND_FILL       = 3'd2,
    KIND_BLEND_FILL = 3'd3,
    KIND_MASK_FILL  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_RECT_LEFT     = 3'd2,
    REG_RECT_TOP      = 3'd3,
    REG_RECT_COLS     = 3'd4,
    REG_RECT_ROWS     = 3'd5,
    REG_DRAW_KIND     = 3'd6,
    REG_FILL_COLOR    = 3'd7
  } reg_e;

  typedef struct packed {
    logic [8:0]        screen_width;
    logic [8:0]        screen_height;
    logic signed [8:0] rect_left;
    logic signed [8:0] rect_top;
    logic [8:0]        rect_cols;
    logic [8:0]        rect_rows;
    logic [2:0]        draw_kind;
    logic [PixW-1:0]   fill_color;
  } cfg_t;

  // Current rectangle pixel position on the screen, with a flag set when it lies inside the screen.
  typedef struct packed {
    logic       vis;
    logic       last;
    logic [8:0] x;
    logic [8:0] y;
    logic [8:0] pitch;
  } walk_t;

endpackage

>>> hdl/blit_cfg_regs.sv
// APB configuration register file for the blitter.
module blit_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blit_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output blit_pkg::cfg_t                cfg_o
);

  blit_pkg::cfg_t  cfg_q;
  blit_pkg::reg_e  sel;
  logic            wr_en;

  assign sel    = blit_pkg::reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= 9'd256;
      cfg_q.screen_height <= 9'd256;
      cfg_q.rect_left     <= 9'sd0;
      cfg_q.rect_top      <= 9'sd0;
      cfg_q.rect_cols     <= 9'd1;
      cfg_q.rect_rows     <= 9'd1;
      cfg_q.draw_kind     <= 3'd0;
      cfg_q.fill_color    <= 32'd0;
    end else if (wr_en) begin
      case (sel)
        blit_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[8:0];
        blit_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[8:0];
        blit_pkg::REG_RECT_LEFT:     cfg_q.rect_left     <= $signed(pwdata[8:0]);
        blit_pkg::REG_RECT_TOP:      cfg_q.rect_top      <= $signed(pwdata[8:0]);
        blit_pkg::REG_RECT_COLS:     cfg_q.rect_cols     <= pwdata[8:0];
        blit_pkg::REG_RECT_ROWS:     cfg_q.rect_rows     <= pwdata[8:0];
        blit_pkg::REG_DRAW_KIND:     cfg_q.draw_kind     <= pwdata[2:0];
        blit_pkg::REG_FILL_COLOR:    cfg_q.fill_color    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      blit_pkg::REG_SCREEN_WIDTH:  prdata = {23'd0, cfg_q.screen_width};
      blit_pkg::REG_SCREEN_HEIGHT: prdata = {23'd0, cfg_q.screen_height};
      blit_pkg::REG_RECT_LEFT:     prdata = {23'd0, cfg_q.rect_left};
      blit_pkg::REG_RECT_TOP:      prdata = {23'd0, cfg_q.rect_top};
      blit_pkg::REG_RECT_COLS:     prdata = {23'd0, cfg_q.rect_cols};
      blit_pkg::REG_RECT_ROWS:     prdata = {23'd0, cfg_q.rect_rows};
      blit_pkg::REG_DRAW_KIND:     prdata = {29'd0, cfg_q.draw_kind};
      blit_pkg::REG_FILL_COLOR:    prdata = cfg_q.fill_color;
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

>>> hdl/blit_walker.sv
// Raster walker: column/row counters and screen clipping of the current pixel.
module blit_walker #(
  parameter int unsigned MAX_SCREEN_WIDTH  = blit_pkg::MaxScreenWidth,
  parameter int unsigned MAX_SCREEN_HEIGHT = blit_pkg::MaxScreenHeight
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  blit_pkg::cfg_t  cfg_i,
  output blit_pkg::walk_t walk_o
);

  logic [7:0]        col_q, col_d, row_q, row_d;
  logic [8:0]        sw, sh, cols, rows;
  logic signed [9:0] x, y;
  logic              last_col, last_row;

  always_comb begin
    sw = (32'(cfg_i.screen_width) > 32'(MAX_SCREEN_WIDTH)) ?
         9'(MAX_SCREEN_WIDTH) : cfg_i.screen_width;
    sh = (32'(cfg_i.screen_height) > 32'(MAX_SCREEN_HEIGHT)) ?
         9'(MAX_SCREEN_HEIGHT) : cfg_i.screen_height;
    cols = (cfg_i.rect_cols == 9'd0) ? 9'd1 :
           ((cfg_i.rect_cols > 9'd256) ? 9'd256 : cfg_i.rect_cols);
    rows = (cfg_i.rect_rows == 9'd0) ? 9'd1 :
           ((cfg_i.rect_rows > 9'd256) ? 9'd256 : cfg_i.rect_rows);
    x = $signed({cfg_i.rect_left[8], cfg_i.rect_left}) + $signed({2'b00, col_q});
    y = $signed({cfg_i.rect_top[8], cfg_i.rect_top}) + $signed({2'b00, row_q});
    last_col = ({1'b0, col_q} + 9'd1) >= cols;
    last_row = ({1'b0, row_q} + 9'd1) >= rows;

    walk_o.vis   = !x[9] && !y[9] && (x[8:0] < sw) && (y[8:0] < sh);
    walk_o.last  = last_col && last_row;
    walk_o.x     = x[8:0];
    walk_o.y     = y[8:0];
    walk_o.pitch = sw;

    col_d = col_q;
    row_d = row_q;
    if (step_i) begin
      if (last_col) begin
        col_d = 8'd0;
        row_d = last_row ? 8'd0 : row_q + 8'd1;
      end else begin
        col_d = col_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 8'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> hdl/blit_pixel_alu.sv
// Pixel operation unit: copy, fill, masked fill and alpha blend.
module blit_pixel_alu (
  input  logic [2:0]                draw_kind_i,
  input  logic [blit_pkg::PixW-1:0] fill_color_i,
  input  logic [blit_pkg::PixW-1:0] src_i,
  input  logic [blit_pkg::PixW-1:0] cur_i,
  output logic [blit_pkg::PixW-1:0] val_o,
  output logic                      go_o
);

  // floor((s*a + d*(255-a)) / 255); exact for sums up to 65279
  function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] d,
                                      input logic [7:0] a);
    logic [15:0] v;
    logic [16:0] t;
    v = 16'(s) * 16'(a) + 16'(d) * 16'(8'd255 - a);
    t = 17'(v) + 17'd1 + 17'(v[15:8]);
    return t[15:8];
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] dst, input logic [31:0] src);
    return {mix8(src[31:24], dst[31:24], src[7:0]),
            mix8(src[23:16], dst[23:16], src[7:0]),
            mix8(src[15:8],  dst[15:8],  src[7:0]),
            8'hFF};
  endfunction

  always_comb begin
    val_o = '0;
    go_o  = 1'b1;
    case (blit_pkg::kind_e'(draw_kind_i))
      blit_pkg::KIND_COPY:       val_o = src_i;
      blit_pkg::KIND_BLEND_SRC:  val_o = blend(cur_i, src_i);
      blit_pkg::KIND_FILL:       val_o = fill_color_i;
      blit_pkg::KIND_BLEND_FILL: val_o = blend(cur_i, fill_color_i);
      blit_pkg::KIND_MASK_FILL: begin
        val_o = fill_color_i & src_i;
        go_o  = |(fill_color_i[7:0] & src_i[7:0]);
      end
      default:                   go_o  = 1'b0;
    endcase
  end

endmodule

>>> hdl/blit_fb_mem.sv
// Framebuffer memory: one synchronous read port, one write port.
module blit_fb_mem #(
  parameter int unsigned MAX_SCREEN_WIDTH  = blit_pkg::MaxScreenWidth,
  parameter int unsigned MAX_SCREEN_HEIGHT = blit_pkg::MaxScreenHeight,
  localparam int unsigned Words = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT,
  localparam int unsigned AddrW = $clog2(Words)
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [blit_pkg::PixW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [blit_pkg::PixW-1:0] wr_data_i
);

  logic [blit_pkg::PixW-1:0] mem [Words];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

>>> hdl/clipped_rect_blit_alpha_blend_top.sv
// Top level of the clipped rectangle blitter with alpha blending.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: source_pixel, access_address; tuser: mode
//  m_axis   | out | m_axis_tvalid/tready   | tdata: read_pixel, pixel_written; tlast: rect_done
//  apb      | in  | psel/penable, pready=1 | paddr, pwdata, prdata
//
// One item per clock unless m_axis stalls; results pass stages 1, 2 and the output register.
// Stage 1 forms the pixel address (one multiply) and reads the framebuffer port;
// stage 2 modifies and writes back, with a forward of the write made in the same cycle.
// A stalled output register holds up to two more requests before s_axis_tready drops.
// Reset clears counters, configuration registers and pipeline valids; the framebuffer is not cleared.
module clipped_rect_blit_alpha_blend_top #(
  parameter int unsigned MAX_SCREEN_WIDTH  = blit_pkg::MaxScreenWidth,
  parameter int unsigned MAX_SCREEN_HEIGHT = blit_pkg::MaxScreenHeight
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,   // source_pixel[31:0], access_address[47:32]
  input  logic [1:0]                    s_axis_tuser,   // mode[1:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [39:0]                   m_axis_tdata,   // read_pixel[31:0], pixel_written[32]
  output logic                          m_axis_tlast,   // rect_done
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [blit_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned Words = MAX_SCREEN_WIDTH * MAX_SCREEN_HEIGHT;
  localparam int unsigned AddrW = $clog2(Words);

  blit_pkg::cfg_t  cfg;
  blit_pkg::walk_t walk;

  logic                  in_acc, step, addr_ok;
  blit_pkg::mode_e       in_mode;

  logic                  v1_q, ok1_q, done1_q;
  blit_pkg::mode_e       mode1_q;
  logic [31:0]           src1_q;
  logic [AddrW-1:0]      addr1_q;
  logic [8:0]            x1_q, y1_q, pitch1_q;
  logic [17:0]           prod1;
  logic [AddrW-1:0]      rd_addr;

  logic                  v2_q, ok2_q, done2_q, fwd_hit2_q;
  blit_pkg::mode_e       mode2_q;
  logic [31:0]           src2_q, fwd_data2_q;
  logic [AddrW-1:0]      idx2_q;

  logic [31:0]           rd_data, cur, alu_val, wr_data;
  logic                  alu_go, we, rd_en, out_free, en2;

  logic                  ov_q, written_q, done_q;
  logic [31:0]           rpix_q;

  blit_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign out_free      = !ov_q || m_axis_tready;
  assign en2           = !v2_q || out_free;
  assign s_axis_tready = !v1_q || en2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_mode       = blit_pkg::mode_e'(s_axis_tuser);
  assign step          = in_acc && (in_mode == blit_pkg::MODE_DRAW);
  assign addr_ok       = 32'(s_axis_tdata[47:32]) < 32'(Words);

  blit_walker #(
    .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
  ) u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cfg_i  (cfg),
    .walk_o (walk)
  );

  // Stage 1: address generation and framebuffer read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (s_axis_tready) begin
      v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode1_q  <= in_mode;
      src1_q   <= s_axis_tdata[31:0];
      addr1_q  <= AddrW'(s_axis_tdata[47:32]);
      ok1_q    <= (in_mode == blit_pkg::MODE_DRAW) ? walk.vis : addr_ok;
      done1_q  <= (in_mode == blit_pkg::MODE_DRAW) && walk.last;
      x1_q     <= walk.x;
      y1_q     <= walk.y;
      pitch1_q <= walk.pitch;
    end
  end

  assign prod1   = 18'(y1_q) * 18'(pitch1_q);
  assign rd_addr = (mode1_q == blit_pkg::MODE_DRAW) ? AddrW'(prod1 + 18'(x1_q)) : addr1_q;
  assign rd_en   = en2 && v1_q;

  blit_fb_mem #(
    .MAX_SCREEN_WIDTH  (MAX_SCREEN_WIDTH),
    .MAX_SCREEN_HEIGHT (MAX_SCREEN_HEIGHT)
  ) u_fb (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (we),
    .wr_addr_i (idx2_q),
    .wr_data_i (wr_data)
  );

  // Stage 2: modify and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q       <= 1'b0;
      fwd_hit2_q <= 1'b0;
    end else if (en2) begin
      v2_q       <= v1_q;
      fwd_hit2_q <= v1_q && we && (idx2_q == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      mode2_q     <= mode1_q;
      src2_q      <= src1_q;
      idx2_q      <= rd_addr;
      ok2_q       <= ok1_q;
      done2_q     <= done1_q;
      fwd_data2_q <= wr_data;
    end
  end

  assign cur = fwd_hit2_q ? fwd_data2_q : rd_data;

  blit_pixel_alu u_alu (
    .draw_kind_i  (cfg.draw_kind),
    .fill_color_i (cfg.fill_color),
    .src_i        (src2_q),
    .cur_i        (cur),
    .val_o        (alu_val),
    .go_o         (alu_go)
  );

  assign wr_data = (mode2_q == blit_pkg::MODE_LOAD) ? src2_q : alu_val;
  assign we      = v2_q && out_free && ok2_q &&
                   (((mode2_q == blit_pkg::MODE_DRAW) && alu_go) ||
                    (mode2_q == blit_pkg::MODE_LOAD));

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_free) begin
      ov_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && v2_q) begin
      rpix_q    <= ((mode2_q == blit_pkg::MODE_READ) && ok2_q) ? cur : 32'd0;
      written_q <= (mode2_q == blit_pkg::MODE_DRAW) && ok2_q && alu_go;
      done_q    <= done2_q;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, written_q, rpix_q};
  assign m_axis_tlast  = done_q;

  a_ready_low_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output backpressure");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit2_q |-> v2_q)
    else $error("forward hit flagged on an empty write-back stage");

  a_done_has_no_read_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("rectangle end reported on a read result");

endmodule

>>> sim/tb_clipped_rect_blit_alpha_blend_top.sv
// Self-checking testbench for the clipped rectangle blitter: stream stimulus, APB setup, result compare.
`timescale 1ns / 100ps

module tb_clipped_rect_blit_alpha_blend_top;
  import blit_pkg::*;

  localparam int unsigned FbWords      = MaxScreenWidth * MaxScreenHeight;
  localparam logic [1:0]  ModeSpare    = 2'd3;
  localparam logic [2:0]  KindUnusedLo = 3'd5;
  localparam logic [2:0]  KindUnusedHi = 3'd7;

  typedef struct packed {
    logic [31:0] read_pixel;
    logic        pixel_written;
    logic        rect_done;
  } blit_outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [47:0]         s_axis_tdata;   // source_pixel[31:0], access_address[47:32]
  logic [1:0]          s_axis_tuser;   // mode[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [39:0]         m_axis_tdata;   // read_pixel[31:0], pixel_written[32]
  logic                m_axis_tlast;   // rect_done
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  clipped_rect_blit_alpha_blend_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // Mirror of the block state
  logic [31:0]       fb_model [FbWords];
  bit                fb_known [FbWords];
  int unsigned       known_addrs[$];
  int unsigned       last_stored;
  logic [7:0]        col_cnt, row_cnt;
  logic [8:0]        scr_w, scr_h, rect_w, rect_h;
  logic signed [8:0] rect_x0, rect_y0;
  logic [2:0]        kind;
  logic [31:0]       fill;

  blit_outcome_t pixel_outcomes[$];
  int unsigned   mismatches;
  int unsigned   items_sent;
  int            sink_hold;
  bit            calm;
  bit            src_gapless;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic int size_of(logic [8:0] v);
    if (v == 9'd0) return 1;
    return (v > 9'd256) ? 256 : int'(v);
  endfunction

  function automatic logic [31:0] blend_over(logic [31:0] dst, logic [31:0] src);
    int unsigned a, s, d, c, sh;
    logic [31:0] res;
    a   = src[7:0];
    res = 32'h0000_00FF;
    for (sh = 8; sh <= 24; sh += 8) begin
      s   = (src >> sh) & 32'hFF;
      d   = (dst >> sh) & 32'hFF;
      c   = (s * a + d * (255 - a)) / 255;
      res = res | ((c & 32'hFF) << sh);
    end
    return res;
  endfunction

  function automatic void fb_store(int unsigned idx, logic [31:0] v);
    if (!fb_known[idx]) known_addrs.push_back(idx);
    fb_known[idx] = 1'b1;
    fb_model[idx] = v;
    last_stored   = idx;
  endfunction

  // Screen position of the next rectangle pixel; returns 1 when it is visible.
  function automatic bit draw_hits(output int idx);
    int sw, sh, x0, y0, x, y;
    sw  = (scr_w > MaxScreenWidth) ? MaxScreenWidth : scr_w;
    sh  = (scr_h > MaxScreenHeight) ? MaxScreenHeight : scr_h;
    x0  = rect_x0;
    y0  = rect_y0;
    x   = x0 + int'(col_cnt);
    y   = y0 + int'(row_cnt);
    idx = y * sw + x;
    return (x >= 0) && (y >= 0) && (x < sw) && (y < sh);
  endfunction

  function automatic blit_outcome_t predict_outcome(logic [1:0] m, logic [31:0] px,
                                                    logic [15:0] addr);
    blit_outcome_t r;
    int            idx;
    bit            hit, go, last_c, last_r;
    logic [31:0]   cur, val;
    r = '0;
    case (m)
      MODE_READ: r.read_pixel = fb_model[addr];
      MODE_LOAD: fb_store(addr, px);
      MODE_DRAW: begin
        last_c = (int'(col_cnt) + 1) >= size_of(rect_w);
        last_r = (int'(row_cnt) + 1) >= size_of(rect_h);
        hit    = draw_hits(idx);
        if (hit) begin
          cur = fb_model[idx];
          val = '0;
          go  = 1'b1;
          case (kind)
            KIND_COPY:       val = px;
            KIND_BLEND_SRC:  val = blend_over(cur, px);
            KIND_FILL:       val = fill;
            KIND_BLEND_FILL: val = blend_over(cur, fill);
            KIND_MASK_FILL: begin
              val = fill & px;
              go  = (val[7:0] != 8'h00);
            end
            default:         go = 1'b0;
          endcase
          if (go) begin
            fb_store(idx, val);
            r.pixel_written = 1'b1;
          end
        end
        if (last_c) begin
          col_cnt = '0;
          if (last_r) begin
            row_cnt     = '0;
            r.rect_done = 1'b1;
          end else begin
            row_cnt = row_cnt + 8'd1;
          end
        end else begin
          col_cnt = col_cnt + 8'd1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_pixel();
    logic [31:0] p;
    p = $urandom();
    case ($urandom_range(0, 3))
      0:       p[7:0] = 8'h00;
      1:       p[7:0] = 8'hFF;
      default: ;
    endcase
    return p;
  endfunction

  task automatic push_item(logic [1:0] m, logic [31:0] px, logic [15:0] addr);
    bit took;
    pixel_outcomes.push_back(predict_outcome(m, px, addr));
    if (m != ModeSpare) items_sent++;
    if (!calm && !src_gapless && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {addr, px};
    s_axis_tuser  <= m;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
  endtask

  // Words are loaded first wherever a read or a blend would touch an unwritten word.
  task automatic send_item(logic [1:0] m, logic [31:0] px, logic [15:0] addr);
    int idx;
    bit hit;
    if (m == MODE_READ && !fb_known[addr]) push_item(MODE_LOAD, rand_pixel(), addr);
    if (m == MODE_DRAW && (kind == KIND_BLEND_SRC || kind == KIND_BLEND_FILL)) begin
      hit = draw_hits(idx);
      if (hit && !fb_known[idx]) push_item(MODE_LOAD, rand_pixel(), 16'(idx));
    end
    push_item(m, px, addr);
  endtask

  task automatic await_idle();
    s_axis_tvalid <= 1'b0;
    while (pixel_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e r, logic [31:0] v, bit junk = 1'b0);
    logic [31:0] keep;
    bit          ok;
    await_idle();
    keep = (r == REG_FILL_COLOR) ? 32'hFFFF_FFFF :
           (r == REG_DRAW_KIND)  ? 32'h0000_0007 : 32'h0000_01FF;
    if (junk) v = v | ($urandom() & ~keep);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      ok = pready;
      @(posedge clk_i);
    end while (!ok);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    v = v & keep;
    case (r)
      REG_SCREEN_WIDTH:  scr_w   = v[8:0];
      REG_SCREEN_HEIGHT: scr_h   = v[8:0];
      REG_RECT_LEFT:     rect_x0 = v[8:0];
      REG_RECT_TOP:      rect_y0 = v[8:0];
      REG_RECT_COLS:     rect_w  = v[8:0];
      REG_RECT_ROWS:     rect_h  = v[8:0];
      REG_DRAW_KIND:     kind    = v[2:0];
      REG_FILL_COLOR:    fill    = v;
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    send_item(MODE_DRAW, 32'hA1B2_C3D4, 16'h0000);
    send_item(MODE_READ, 32'h0000_0000, 16'h0000);
    send_item(MODE_LOAD, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(MODE_READ, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ModeSpare, 32'hFFFF_FFFF, 16'hFFFF);
  endtask

  // First pixel clipped on the left, second lands on word 0.
  task automatic draw_pair(logic [2:0] k, logic [31:0] px);
    reg_write(REG_DRAW_KIND, 32'(k));
    repeat (2) send_item(MODE_DRAW, px, 16'h0000);
    send_item(MODE_READ, 32'h0, 16'h0000);
  endtask

  task automatic test_draw_kinds();
    reg_write(REG_SCREEN_WIDTH, 32'd16);
    reg_write(REG_SCREEN_HEIGHT, 32'd8);
    reg_write(REG_RECT_LEFT, 32'h1FF);
    reg_write(REG_RECT_TOP, 32'h000);
    reg_write(REG_RECT_COLS, 32'd2);
    reg_write(REG_RECT_ROWS, 32'd1);
    reg_write(REG_FILL_COLOR, 32'h4080_C080);
    draw_pair(KIND_COPY, 32'h1122_3344);
    draw_pair(KIND_BLEND_SRC, 32'hF0F0_F080);
    draw_pair(KIND_FILL, 32'h0000_0000);
    draw_pair(KIND_BLEND_FILL, 32'h5555_5555);
    draw_pair(KIND_MASK_FILL, 32'hFFFF_FF00);
    draw_pair(KIND_MASK_FILL, 32'h0F0F_0FFF);
    draw_pair(KindUnusedLo, 32'hDEAD_BEEF);
  endtask

  task automatic test_corner_cases();
    reg_write(REG_DRAW_KIND, 32'(KIND_COPY));
    reg_write(REG_RECT_COLS, 32'd1);
    reg_write(REG_RECT_LEFT, 32'h000);
    // zero-width screen
    reg_write(REG_SCREEN_WIDTH, 32'd0);
    send_item(MODE_DRAW, 32'h0102_0304, 16'h0000);
    // oversized screen saturates; bottom-right corner word
    reg_write(REG_SCREEN_WIDTH, 32'd300);
    reg_write(REG_SCREEN_HEIGHT, 32'd511);
    reg_write(REG_RECT_LEFT, 32'h0FF);
    reg_write(REG_RECT_TOP, 32'h0FF);
    send_item(MODE_DRAW, 32'h8899_AABB, 16'h1234);
    send_item(MODE_READ, 32'h0, 16'hFFFF);
    reg_write(REG_SCREEN_HEIGHT, 32'd0);
    send_item(MODE_DRAW, 32'h0000_00FF, 16'h0000);
    reg_write(REG_SCREEN_HEIGHT, 32'd256);
    // sizes out of range, far corner of the signed origin
    reg_write(REG_RECT_LEFT, 32'h100);
    reg_write(REG_RECT_TOP, 32'h100);
    reg_write(REG_RECT_COLS, 32'd0);
    reg_write(REG_RECT_ROWS, 32'd400);
    repeat (2) send_item(MODE_DRAW, 32'h1357_9BDF, 16'h0000);
    // row counter beyond a shrunk height
    reg_write(REG_RECT_ROWS, 32'd1);
    send_item(MODE_DRAW, 32'h2468_ACE0, 16'h0000);
    // column counter beyond a shrunk width
    reg_write(REG_RECT_LEFT, 32'h000);
    reg_write(REG_RECT_TOP, 32'h000);
    reg_write(REG_RECT_COLS, 32'd5);
    repeat (3) send_item(MODE_DRAW, 32'hCAFE_F00D, 16'h0000);
    reg_write(REG_RECT_COLS, 32'd2);
    send_item(MODE_DRAW, 32'hFACE_0001, 16'h0000);
    // fill color extremes
    reg_write(REG_RECT_COLS, 32'd1);
    reg_write(REG_FILL_COLOR, 32'hFFFF_FFFF);
    reg_write(REG_DRAW_KIND, 32'(KIND_FILL));
    send_item(MODE_DRAW, 32'h0, 16'h0000);
    reg_write(REG_FILL_COLOR, 32'h0000_0000);
    reg_write(REG_DRAW_KIND, 32'(KIND_MASK_FILL));
    send_item(MODE_DRAW, 32'hFFFF_FFFF, 16'h0000);
    send_item(MODE_READ, 32'h0, 16'h0000);
  endtask

  // Output held off for a long stretch while the input keeps offering requests.
  task automatic test_backpressure();
    reg_write(REG_SCREEN_WIDTH, 32'd256);
    reg_write(REG_SCREEN_HEIGHT, 32'd256);
    reg_write(REG_RECT_COLS, 32'd16);
    reg_write(REG_RECT_ROWS, 32'd4);
    reg_write(REG_DRAW_KIND, 32'(KIND_COPY));
    src_gapless = 1'b1;
    sink_hold   = 60;
    repeat (64) send_item(MODE_DRAW, rand_pixel(), 16'($urandom()));
    src_gapless = 1'b0;
  endtask

  task automatic run_random_phases(int unsigned budget);
    int unsigned stop_at, n, sw, sh, eff_w, eff_h, cols, rows;
    int          l, t;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0:       sw = 0;
        1:       sw = 256;
        2:       sw = $urandom_range(257, 511);
        default: sw = $urandom_range(1, 24);
      endcase
      case ($urandom_range(0, 9))
        0:       sh = 0;
        1:       sh = 256;
        2:       sh = $urandom_range(257, 511);
        default: sh = $urandom_range(1, 24);
      endcase
      eff_w = (sw > 256) ? 256 : sw;
      eff_h = (sh > 256) ? 256 : sh;
      l = int'($urandom_range(0, eff_w + 8)) - 8;
      t = int'($urandom_range(0, eff_h + 8)) - 8;
      if ($urandom_range(0, 9) == 0) l = int'($urandom_range(0, 511)) - 256;
      if ($urandom_range(0, 9) == 0) t = int'($urandom_range(0, 511)) - 256;
      if (l > 255) l = 255;
      if (t > 255) t = 255;
      case ($urandom_range(0, 11))
        0:       cols = 0;
        1:       cols = 256;
        2:       cols = $urandom_range(257, 511);
        default: cols = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 11))
        0:       rows = 0;
        1:       rows = 256;
        2:       rows = $urandom_range(257, 511);
        default: rows = $urandom_range(1, 6);
      endcase
      reg_write(REG_SCREEN_WIDTH, sw, $urandom_range(0, 3) == 0);
      reg_write(REG_SCREEN_HEIGHT, sh, $urandom_range(0, 3) == 0);
      reg_write(REG_RECT_LEFT, 32'(l) & 32'h1FF, $urandom_range(0, 3) == 0);
      reg_write(REG_RECT_TOP, 32'(t) & 32'h1FF, $urandom_range(0, 3) == 0);
      reg_write(REG_RECT_COLS, cols, $urandom_range(0, 3) == 0);
      reg_write(REG_RECT_ROWS, rows, $urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0)
        reg_write(REG_DRAW_KIND, $urandom_range(KindUnusedLo, KindUnusedHi));
      else
        reg_write(REG_DRAW_KIND, $urandom_range(KIND_COPY, KIND_MASK_FILL),
                  $urandom_range(0, 3) == 0);
      reg_write(REG_FILL_COLOR, rand_pixel());
      n = size_of(cols) * size_of(rows);
      if (n > 64) n = $urandom_range(1, 40);
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
      repeat (n) begin
        case ($urandom_range(0, 19))
          0: send_item(MODE_READ, $urandom(),
                       16'(known_addrs[$urandom_range(0, known_addrs.size() - 1)]));
          1: send_item(MODE_LOAD, $urandom(), 16'($urandom()));
          2: send_item(ModeSpare, $urandom(), 16'($urandom()));
          3: send_item(MODE_READ, $urandom(), 16'(last_stored));
          default: ;
        endcase
        send_item(MODE_DRAW, rand_pixel(), 16'($urandom()));
      end
    end
  endtask

  initial begin : result_check
    blit_outcome_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (pixel_outcomes.size() == 0) begin
          report_mismatch("result without request", m_axis_tdata[31:0], 32'h0);
        end else begin
          want = pixel_outcomes.pop_front();
          if (m_axis_tdata[31:0] !== want.read_pixel)
            report_mismatch("read_pixel", m_axis_tdata[31:0], want.read_pixel);
          if (m_axis_tdata[32] !== want.pixel_written)
            report_mismatch("pixel_written", 32'(m_axis_tdata[32]), 32'(want.pixel_written));
          if (m_axis_tlast !== want.rect_done)
            report_mismatch("rect_done", 32'(m_axis_tlast), 32'(want.rect_done));
        end
      end
    end
  end

  initial begin : sink_pacing
    int unsigned gap_left;
    gap_left      = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready <= 1'b0;
        sink_hold--;
      end else if (gap_left > 0) begin
        m_axis_tready <= 1'b0;
        gap_left--;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        gap_left = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #1_600_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : main_seq
    int unsigned guard;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mismatches    = 0;
    items_sent    = 0;
    sink_hold     = 0;
    calm          = 1'b0;
    src_gapless   = 1'b0;
    last_stored   = 0;
    col_cnt       = '0;
    row_cnt       = '0;
    scr_w         = 9'd256;
    scr_h         = 9'd256;
    rect_x0       = '0;
    rect_y0       = '0;
    rect_w        = 9'd1;
    rect_h        = 9'd1;
    kind          = KIND_COPY;
    fill          = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_draw_kinds();
    test_corner_cases();
    test_backpressure();
    run_random_phases(380);
    calm = 1'b1;
    run_random_phases(100);

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pixel_outcomes.size() != 0 && guard < 2000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
    if (pixel_outcomes.size() != 0)
      report_mismatch("results missing", pixel_outcomes.size(), 32'h0);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/blit_pkg.sv
hdl/blit_cfg_regs.sv
hdl/blit_walker.sv
hdl/blit_pixel_alu.sv
hdl/blit_fb_mem.sv
hdl/clipped_rect_blit_alpha_blend_top.sv
sim/tb_clipped_rect_blit_alpha_blend_top.sv
